[rtl/pol_pkg.sv]
// Shared types and codes for the positional ordered list.
// Request/result transaction structs, op codes and status codes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pol_pkg;

  // Request op codes (code 3 is unused and does nothing)
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Request transaction
  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  position;
    logic [31:0] element;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [5:0]  entry_count;
    logic [31:0] first_value;
    logic [31:0] last_value;
  } out_t;

endpackage

`default_nettype wire

[rtl/positional_ordered_list.sv]
// Top level of the positional ordered list: request sequencer, count and result register.
// Depends on pol_pkg (types, codes) and pol_ram (entry storage).
//
//  Port group   | Dir | Handshake                 | Payload
//  -------------+-----+---------------------------+-------------------------
//  request      | in  | in_valid_i / in_ready_o   | in_data_i  (pol_pkg::in_t)
//  result       | out | out_valid_o / out_ready_i | out_data_o (pol_pkg::out_t)
//
// One request at a time; in_ready_o is high only while the sequencer is idle.
// Insert and delete shift the entries past the position one by one; every request then
// reads head and tail before its result is loaded.
// The single RAM port pair moves one entry at a time (registered read, then write).
// A finished result sits in the output register while the next request is taken;
// the sequencer stalls only if a second result is ready before the first is taken.
// Reset clears count and control; entry contents are not cleared (never read unwritten).
`timescale 1ns / 1ps
`default_nettype none

module positional_ordered_list #(
  parameter int unsigned CAPACITY   = 32,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire pol_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output pol_pkg::out_t      out_data_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned MW = (CW > 6) ? CW : 6;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_READ     = 8'b0000_0010,
    S_SHIFT_RD = 8'b0000_0100,
    S_SHIFT_WR = 8'b0000_1000,
    S_PUT      = 8'b0001_0000,
    S_FIRST    = 8'b0010_0000,
    S_LAST     = 8'b0100_0000,
    S_TAIL     = 8'b1000_0000
  } state_e;

  state_e                  state_q, state_d;
  logic [1:0]              op_q, op_d;
  logic [AW-1:0]           pos_q, pos_d;
  logic [AW-1:0]           idx_q, idx_d;
  logic [DATA_WIDTH-1:0]   elem_q, elem_d;
  logic [CW-1:0]           count_q, count_d;
  pol_pkg::status_e        status_q, status_d;
  logic [DATA_WIDTH-1:0]   rdv_q, rdv_d;
  logic [DATA_WIDTH-1:0]   first_q, first_d;
  pol_pkg::out_t           out_q, out_d;
  logic                    out_valid_q, out_valid_d;

  // RAM port signals
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [DATA_WIDTH-1:0]   ram_wdata;
  logic [AW-1:0]           ram_raddr;
  logic [DATA_WIDTH-1:0]   ram_rdata;

  // Request position and count in a common width for compares
  logic [MW-1:0]           pos_ext;
  logic [MW-1:0]           cnt_ext;
  logic [MW-1:0]           eff_pos;
  logic                    in_fire;
  logic                    out_free;

  assign pos_ext  = MW'(in_data_i.position);
  assign cnt_ext  = MW'(count_q);
  assign in_fire  = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || out_ready_i;

  pol_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer and datapath next-state logic
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    elem_d      = elem_q;
    count_d     = count_q;
    status_d    = status_q;
    rdv_d       = rdv_q;
    first_d     = first_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    eff_pos     = '0;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = ram_rdata;
    ram_raddr   = '0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d     = in_data_i.op;
          elem_d   = DATA_WIDTH'(in_data_i.element);
          rdv_d    = '0;
          first_d  = '0;
          status_d = pol_pkg::ST_OK;
          state_d  = S_FIRST;
          case (in_data_i.op)
            pol_pkg::OP_INSERT: begin
              if (count_q == CW'(CAPACITY)) begin
                status_d = pol_pkg::ST_FULL;
              end else begin
                eff_pos = (pos_ext > cnt_ext) ? cnt_ext : pos_ext;
                pos_d   = AW'(eff_pos);
                idx_d   = AW'(count_q);
                state_d = (eff_pos == cnt_ext) ? S_PUT : S_SHIFT_RD;
              end
            end
            pol_pkg::OP_DELETE: begin
              if (count_q == '0) begin
                status_d = pol_pkg::ST_EMPTY;
              end else begin
                eff_pos = (pos_ext >= cnt_ext) ? (cnt_ext - MW'(1)) : pos_ext;
                idx_d   = AW'(eff_pos);
                if ((eff_pos + MW'(1)) < cnt_ext) begin
                  state_d = S_SHIFT_RD;
                end else begin
                  count_d = count_q - CW'(1);
                end
              end
            end
            pol_pkg::OP_READ: begin
              if (pos_ext >= cnt_ext) begin
                status_d = pol_pkg::ST_RANGE;
              end else begin
                pos_d   = AW'(in_data_i.position);
                state_d = S_READ;
              end
            end
            default: begin
              // unused op: no change, report count and head/tail only
            end
          endcase
        end
      end

      S_READ: begin
        ram_raddr = pos_q;
        state_d   = S_FIRST;
      end

      // Fetch the neighbor that moves into slot idx
      S_SHIFT_RD: begin
        ram_raddr = (op_q == pol_pkg::OP_INSERT) ? (idx_q - AW'(1)) : (idx_q + AW'(1));
        state_d   = S_SHIFT_WR;
      end

      S_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = ram_rdata;
        if (op_q == pol_pkg::OP_INSERT) begin
          idx_d   = idx_q - AW'(1);
          state_d = ((idx_q - AW'(1)) == pos_q) ? S_PUT : S_SHIFT_RD;
        end else begin
          idx_d = idx_q + AW'(1);
          if ((CW'(idx_q) + CW'(2)) >= count_q) begin
            count_d = count_q - CW'(1);
            state_d = S_FIRST;
          end else begin
            state_d = S_SHIFT_RD;
          end
        end
      end

      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = elem_q;
        count_d   = count_q + CW'(1);
        state_d   = S_FIRST;
      end

      // Capture read result (if any), fetch head
      S_FIRST: begin
        ram_raddr = '0;
        if ((op_q == pol_pkg::OP_READ) && (status_q == pol_pkg::ST_OK)) begin
          rdv_d = ram_rdata;
        end
        state_d = (count_q == '0) ? S_TAIL : S_LAST;
      end

      // Capture head, fetch tail
      S_LAST: begin
        ram_raddr = AW'(count_q - CW'(1));
        first_d   = ram_rdata;
        state_d   = S_TAIL;
      end

      // Tail read held until the result register frees up
      S_TAIL: begin
        ram_raddr = AW'(count_q - CW'(1));
        if (out_free) begin
          out_d.status      = status_q;
          out_d.read_value  = 32'(rdv_q);
          out_d.entry_count = 6'(count_q);
          out_d.first_value = 32'(first_q);
          out_d.last_value  = (count_q == '0) ? '0 : 32'(ram_rdata);
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      op_q        <= '0;
      status_q    <= pol_pkg::ST_OK;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      op_q        <= op_d;
      status_q    <= status_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    idx_q   <= idx_d;
    elem_q  <= elem_d;
    rdv_q   <= rdv_d;
    first_q <= first_d;
    out_q   <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[rtl/pol_ram.sv]
// Entry storage for the positional ordered list: one write port, one read port.
// Read data is registered; contents are undefined until written. No package use.
`timescale 1ns / 1ps
`default_nettype none

module pol_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/pol_checker.sv]
// Port-level checks for positional_ordered_list, attached by bind.
// Depends on pol_pkg for the transaction types and status codes.
`timescale 1ns / 1ps
`default_nettype none

module pol_checker #(
  parameter int unsigned CAPACITY = 32
) (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_ready_o,
  input wire pol_pkg::in_t  in_data_i,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire pol_pkg::out_t out_data_o
);

  // A stalled result transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Sequencer is busy the cycle after a request transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  // Empty report shows a cleared list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == pol_pkg::ST_EMPTY) |->
      (out_data_o.entry_count == '0) && (out_data_o.first_value == '0) &&
      (out_data_o.last_value == '0))
    else $error("empty status with entries");

  // Full report shows the list at capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == pol_pkg::ST_FULL) |->
      (out_data_o.entry_count == 6'(CAPACITY)))
    else $error("full status below capacity");

  // Out-of-range read returns zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == pol_pkg::ST_RANGE) |->
      (out_data_o.read_value == '0))
    else $error("range status with read data");

endmodule

bind positional_ordered_list pol_checker #(
  .CAPACITY (CAPACITY)
) u_pol_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
